>>> rtl/tcf_pkg.sv
// Shared types, constants and the glyph ROM of the text console framebuffer.
// Used by the configuration registers, the draw engine and the top level.
package tcf_pkg;

  localparam int ROM_GLYPHS   = 45;
  localparam int CUR_START    = 4;
  localparam int CUR_X_MAX    = 1020;
  localparam int CUR_X_STEP   = 4;
  localparam int LINE_STEP    = 8;
  localparam int LINE_MARGIN  = 12;
  localparam int GLYPH_ROWS   = 5;

  localparam logic [7:0] CHAR_LF        = 8'd10;
  localparam logic [7:0] CHAR_CR        = 8'd13;
  localparam logic [7:0] CHAR_PLUS      = 8'd43;
  localparam logic [7:0] CHAR_DOT       = 8'd46;
  localparam logic [7:0] CHAR_ZERO      = 8'd48;
  localparam logic [7:0] CHAR_AT        = 8'd64;
  localparam logic [7:0] CHAR_BACKSLASH = 8'd92;
  localparam logic [7:0] CHAR_LOWER_A   = 8'd97;
  localparam logic [7:0] CASE_SHIFT     = 8'd32;

  localparam logic [7:0] NIB_LO_MASK = 8'h0F;
  localparam logic [7:0] NIB_HI_MASK = 8'hF0;

  localparam logic [2:0] TEXT_COLOR_RESET    = 3'd7;
  localparam logic [2:0] ADDR_TEXT_COLOR     = 3'd0;

  typedef enum logic [1:0] {
    REQ_PRINT = 2'd0,
    REQ_PIXEL = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SWEEP,
    ST_ISSUE,
    ST_WRITE,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    req_t        req_type;
    logic [7:0]  char_code;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [2:0]  color;
    logic [13:0] read_address;
  } req_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [9:0] cursor_col_pos;
    logic [7:0] cursor_row_pos;
    logic       screen_cleared;
  } res_t;

  function automatic logic [14:0] rows5(input logic [2:0] a, input logic [2:0] b,
                                        input logic [2:0] c, input logic [2:0] d,
                                        input logic [2:0] e);
    return {e, d, c, b, a};
  endfunction

  // One entry holds the same row of five neighboring glyphs, 3 bits each.
  localparam logic [14:0] GLYPH_ROM [ROM_GLYPHS] = '{
    rows5(7,2,7,6,5), rows5(5,6,1,1,5), rows5(5,2,2,6,7), rows5(5,2,4,1,1), rows5(7,7,7,6,1),
    rows5(7,7,7,7,7), rows5(4,4,1,5,5), rows5(7,7,2,7,7), rows5(1,5,2,5,1), rows5(7,7,2,7,7),
    rows5(0,0,1,0,4), rows5(2,2,2,7,2), rows5(0,0,4,0,1), rows5(2,2,2,7,2), rows5(0,4,1,0,4),
    rows5(2,0,2,6,3), rows5(5,2,5,5,4), rows5(1,7,7,6,4), rows5(0,2,5,5,4), rows5(2,0,5,6,3),
    rows5(6,7,7,3,5), rows5(5,4,4,4,5), rows5(5,6,7,5,7), rows5(5,4,4,5,5), rows5(6,7,4,3,5),
    rows5(7,7,5,4,5), rows5(2,1,5,4,7), rows5(2,1,6,4,7), rows5(2,1,5,4,5), rows5(7,6,5,7,5),
    rows5(6,3,6,2,6), rows5(5,5,5,5,5), rows5(5,5,6,5,6), rows5(5,5,4,5,5), rows5(5,2,4,3,5),
    rows5(3,7,5,5,5), rows5(4,2,5,5,5), rows5(2,2,5,5,7), rows5(1,2,5,2,7), rows5(6,2,7,2,5),
    rows5(5,5,7,3,0), rows5(5,5,1,2,0), rows5(2,2,2,2,0), rows5(5,2,4,2,0), rows5(5,2,7,3,2)
  };

  // Three pixels of one glyph row, bit 2 is the left pixel.
  function automatic logic [2:0] glyph_row(input logic [5:0] idx, input logic [2:0] row);
    logic [5:0]  base;
    logic [2:0]  sub;
    logic [5:0]  pos;
    logic [14:0] word;
    base = '0;
    for (int k = 1; k < 9; k++) begin
      if (idx >= 6'(GLYPH_ROWS * k)) base = 6'(GLYPH_ROWS * k);
    end
    sub  = 3'(idx - base);
    pos  = base + 6'(row);
    word = (pos < 6'(ROM_GLYPHS)) ? GLYPH_ROM[pos] : '0;
    case (sub)
      3'd0:    return word[2:0];
      3'd1:    return word[5:3];
      3'd2:    return word[8:6];
      3'd3:    return word[11:9];
      3'd4:    return word[14:12];
      default: return 3'd0;
    endcase
  endfunction

endpackage

>>> rtl/tcf_cfg_regs.sv
// APB-style register file of the text console: holds the glyph text color.
// Depends on tcf_pkg for the register address and reset value.
module tcf_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [2:0]  text_color
);

  logic [2:0] text_color_r;
  logic [2:0] text_color_nxt;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == tcf_pkg::ADDR_TEXT_COLOR);

  always_comb begin
    text_color_nxt = text_color_r;
    if (wr_en) text_color_nxt = pwdata[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= tcf_pkg::TEXT_COLOR_RESET;
    end else begin
      text_color_r <= text_color_nxt;
    end
  end

  assign prdata     = (paddr == tcf_pkg::ADDR_TEXT_COLOR) ? {29'd0, text_color_r} : 32'd0;
  assign text_color = text_color_r;

endmodule

>>> rtl/tcf_engine.sv
// Draw engine: frame store memory, text cursor and the request sequencer.
// Depends on tcf_pkg for request codes, states, item structs and the glyph ROM.
module tcf_engine #(
  parameter int DISPLAY_WIDTH  = 176,
  parameter int DISPLAY_HEIGHT = 176,
  parameter int GLYPH_COUNT    = 45
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  tcf_pkg::req_item_t  req,
  input  logic [2:0]          text_color,
  output logic                res_valid,
  input  logic                res_take,
  output tcf_pkg::res_t       res
);

  localparam int STRIDE      = (DISPLAY_WIDTH + 1) / 2;
  localparam int FRAME_BYTES = STRIDE * DISPLAY_HEIGHT;
  localparam int AW          = $clog2(FRAME_BYTES);
  localparam int GLYPH_LIMIT = (GLYPH_COUNT < tcf_pkg::ROM_GLYPHS) ? GLYPH_COUNT
                                                                   : tcf_pkg::ROM_GLYPHS;

  // Frame store, one synchronous read port and one write port.
  logic [7:0]    mem [FRAME_BYTES];
  logic [7:0]    mem_q_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_q_r <= mem[mem_raddr];
  end

  tcf_pkg::state_t state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    fill_r, fill_nxt;
  logic [9:0]    text_x_r, text_x_nxt;
  logic [7:0]    text_y_r, text_y_nxt;
  logic [9:0]    wx_r, wx_nxt;
  logic [7:0]    wy_r, wy_nxt;
  logic [2:0]    row_r, row_nxt;
  logic          sel_r, sel_nxt;
  logic          glyph_mode_r, glyph_mode_nxt;
  logic [5:0]    gidx_r, gidx_nxt;
  logic [2:0]    color_r, color_nxt;
  logic [AW-1:0] waddr_r, waddr_nxt;
  logic [7:0]    wmask_r, wmask_nxt;
  logic [AW-1:0] raddr_r, raddr_nxt;
  logic          raddr_ok_r, raddr_ok_nxt;
  logic [7:0]    rdata_r, rdata_nxt;
  logic          cleared_r, cleared_nxt;

  // Character decode for a print request.
  logic [7:0]  mcode;
  logic [7:0]  idx8;
  logic        glyph_ok;
  logic        wrap;
  logic [10:0] tx_sum;

  always_comb begin
    mcode = req.char_code;
    if (req.char_code == tcf_pkg::CHAR_DOT)       mcode = tcf_pkg::CHAR_BACKSLASH;
    else if (req.char_code == tcf_pkg::CHAR_PLUS) mcode = tcf_pkg::CHAR_AT;
    if (mcode >= tcf_pkg::CHAR_LOWER_A) mcode = mcode - tcf_pkg::CASE_SHIFT;
    idx8     = mcode - tcf_pkg::CHAR_ZERO;
    glyph_ok = !req.char_code[7] && (mcode >= tcf_pkg::CHAR_ZERO) &&
               (idx8 < 8'(GLYPH_LIMIT));
  end

  assign wrap   = ({2'b00, text_y_r} + 10'(tcf_pkg::LINE_MARGIN)) > 10'(DISPLAY_HEIGHT);
  assign tx_sum = {1'b0, text_x_r} + 11'(tcf_pkg::CUR_X_STEP);

  // Current byte of a glyph row or of a single pixel.
  logic [8:0]  cb;
  logic [8:0]  ysum;
  logic [2:0]  rowbits;
  logic        lo_bit, hi_bit;
  logic        lo_on, hi_on;
  logic        y_ok;
  logic [16:0] pix_addr;
  logic [7:0]  pat;

  always_comb begin
    cb      = wx_r[9:1] + {8'd0, sel_r};
    ysum    = {1'b0, wy_r} + {6'd0, row_r};
    rowbits = glyph_mode_r ? tcf_pkg::glyph_row(gidx_r, row_r) : 3'b100;
    case ({sel_r, wx_r[0]})
      2'b00:   begin lo_bit = rowbits[2]; hi_bit = rowbits[1]; end
      2'b01:   begin lo_bit = 1'b0;       hi_bit = rowbits[2]; end
      2'b10:   begin lo_bit = rowbits[0]; hi_bit = 1'b0;       end
      2'b11:   begin lo_bit = rowbits[1]; hi_bit = rowbits[0]; end
      default: begin lo_bit = 1'b0;       hi_bit = 1'b0;       end
    endcase
    y_ok     = ysum < 9'(DISPLAY_HEIGHT);
    lo_on    = lo_bit && y_ok && ({1'b0, cb, 1'b0} < 11'(DISPLAY_WIDTH));
    hi_on    = hi_bit && y_ok && ({1'b0, cb, 1'b1} < 11'(DISPLAY_WIDTH));
    pix_addr = 17'(ysum[7:0]) * 17'(STRIDE) + 17'(cb);
    pat      = {1'b0, color_r, 1'b0, color_r};
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    fill_nxt       = fill_r;
    text_x_nxt     = text_x_r;
    text_y_nxt     = text_y_r;
    wx_nxt         = wx_r;
    wy_nxt         = wy_r;
    row_nxt        = row_r;
    sel_nxt        = sel_r;
    glyph_mode_nxt = glyph_mode_r;
    gidx_nxt       = gidx_r;
    color_nxt      = color_r;
    waddr_nxt      = waddr_r;
    wmask_nxt      = wmask_r;
    raddr_nxt      = raddr_r;
    raddr_ok_nxt   = raddr_ok_r;
    rdata_nxt      = rdata_r;
    cleared_nxt    = cleared_r;
    req_ready      = 1'b0;
    res_valid      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cnt_r;
    mem_wdata      = fill_r;
    mem_raddr      = raddr_r;

    case (state_r)
      tcf_pkg::ST_INIT, tcf_pkg::ST_SWEEP: begin
        mem_we = 1'b1;
        if (cnt_r == AW'(FRAME_BYTES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = (state_r == tcf_pkg::ST_INIT) ? tcf_pkg::ST_IDLE : tcf_pkg::ST_DONE;
        end else begin
          cnt_nxt = cnt_r + AW'(1);
        end
      end

      tcf_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          rdata_nxt      = '0;
          cleared_nxt    = 1'b0;
          row_nxt        = '0;
          sel_nxt        = 1'b0;
          state_nxt      = tcf_pkg::ST_DONE;
          case (req.req_type)
            tcf_pkg::REQ_PRINT: begin
              // Draw at the cursor as it stands, then move it.
              wx_nxt         = text_x_r;
              wy_nxt         = text_y_r;
              glyph_mode_nxt = 1'b1;
              gidx_nxt       = idx8[5:0];
              color_nxt      = text_color;
              if (glyph_ok) state_nxt = tcf_pkg::ST_ISSUE;
              if (req.char_code == tcf_pkg::CHAR_LF) begin
                if (wrap) begin
                  fill_nxt    = '0;
                  cleared_nxt = 1'b1;
                  text_y_nxt  = 8'(tcf_pkg::CUR_START);
                  state_nxt   = tcf_pkg::ST_SWEEP;
                end else begin
                  text_y_nxt = text_y_r + 8'(tcf_pkg::LINE_STEP);
                end
              end else if (req.char_code == tcf_pkg::CHAR_CR) begin
                text_x_nxt = 10'(tcf_pkg::CUR_START);
              end else begin
                text_x_nxt = (tx_sum > 11'(tcf_pkg::CUR_X_MAX)) ? 10'(tcf_pkg::CUR_X_MAX)
                                                                : tx_sum[9:0];
              end
            end
            tcf_pkg::REQ_PIXEL: begin
              wx_nxt         = {2'b00, req.pixel_x};
              wy_nxt         = req.pixel_y;
              glyph_mode_nxt = 1'b0;
              color_nxt      = req.color;
              state_nxt      = tcf_pkg::ST_ISSUE;
            end
            tcf_pkg::REQ_CLEAR: begin
              fill_nxt    = {1'b0, req.color, 1'b0, req.color};
              cleared_nxt = 1'b1;
              state_nxt   = tcf_pkg::ST_SWEEP;
            end
            tcf_pkg::REQ_READ: begin
              raddr_nxt    = AW'(req.read_address);
              raddr_ok_nxt = 17'(req.read_address) < 17'(FRAME_BYTES);
              state_nxt    = tcf_pkg::ST_READ;
            end
            default: state_nxt = tcf_pkg::ST_DONE;
          endcase
        end
      end

      tcf_pkg::ST_ISSUE, tcf_pkg::ST_WRITE: begin
        mem_raddr = AW'(pix_addr);
        if (state_r == tcf_pkg::ST_ISSUE && (lo_on || hi_on)) begin
          // Fetch the byte; merge and write back next cycle.
          waddr_nxt = AW'(pix_addr);
          wmask_nxt = (lo_on ? tcf_pkg::NIB_LO_MASK : 8'h00) |
                      (hi_on ? tcf_pkg::NIB_HI_MASK : 8'h00);
          state_nxt = tcf_pkg::ST_WRITE;
        end else begin
          if (state_r == tcf_pkg::ST_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = waddr_r;
            mem_wdata = (mem_q_r & ~wmask_r) | (pat & wmask_r);
          end
          state_nxt = tcf_pkg::ST_ISSUE;
          if (!sel_r) begin
            sel_nxt = 1'b1;
          end else begin
            sel_nxt = 1'b0;
            if (row_r == (glyph_mode_r ? 3'(tcf_pkg::GLYPH_ROWS - 1) : 3'd0)) begin
              state_nxt = tcf_pkg::ST_DONE;
            end else begin
              row_nxt = row_r + 3'd1;
            end
          end
        end
      end

      tcf_pkg::ST_READ: begin
        mem_raddr = raddr_r;
        state_nxt = tcf_pkg::ST_READ_WAIT;
      end

      tcf_pkg::ST_READ_WAIT: begin
        rdata_nxt = raddr_ok_r ? mem_q_r : 8'd0;
        state_nxt = tcf_pkg::ST_DONE;
      end

      tcf_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_take) state_nxt = tcf_pkg::ST_IDLE;
      end

      default: state_nxt = tcf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= tcf_pkg::ST_INIT;
      cnt_r    <= '0;
      fill_r   <= '0;
      text_x_r <= 10'(tcf_pkg::CUR_START);
      text_y_r <= 8'(tcf_pkg::CUR_START);
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      fill_r   <= fill_nxt;
      text_x_r <= text_x_nxt;
      text_y_r <= text_y_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wx_r         <= wx_nxt;
    wy_r         <= wy_nxt;
    row_r        <= row_nxt;
    sel_r        <= sel_nxt;
    glyph_mode_r <= glyph_mode_nxt;
    gidx_r       <= gidx_nxt;
    color_r      <= color_nxt;
    waddr_r      <= waddr_nxt;
    wmask_r      <= wmask_nxt;
    raddr_r      <= raddr_nxt;
    raddr_ok_r   <= raddr_ok_nxt;
    rdata_r      <= rdata_nxt;
    cleared_r    <= cleared_nxt;
  end

  assign res.read_data      = rdata_r;
  assign res.cursor_col_pos = text_x_r;
  assign res.cursor_row_pos = text_y_r;
  assign res.screen_cleared = cleared_r;

endmodule

>>> rtl/text_console_framebuffer_top.sv
// Sequence from the accepting edge to out_valid: a print that draws no glyph goes straight to the
// result; else the 10 glyph bytes are visited in ST_ISSUE, a touched byte being read there and
// merged and written back in ST_WRITE; a set pixel does the same; a read passes ST_READ and
// ST_READ_WAIT; clear and newline wrap sweep FRAME_BYTES, one frame byte a cycle. One request at
// a time; the next beat is taken once the result has moved to the output register. Reset: sync,
// active low; a pass then zeroes all FRAME_BYTES (15488 at the default size) with in_ready low.
// Text color resets to 7. Depends on tcf_pkg, tcf_cfg_regs and tcf_engine.
module text_console_framebuffer_top #(
  parameter int DISPLAY_WIDTH  = 176,
  parameter int DISPLAY_HEIGHT = 176,
  parameter int GLYPH_COUNT    = 45
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  logic [2:0]  in_color,
  input  logic [13:0] in_read_address,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic [9:0]  out_cursor_col_pos,
  output logic [7:0]  out_cursor_row_pos,
  output logic        out_screen_cleared,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0]         text_color_w;
  tcf_pkg::req_item_t req_item;
  tcf_pkg::res_t      res;
  tcf_pkg::res_t      out_res_r, out_res_nxt;
  logic               res_valid;
  logic               res_take;
  logic               out_valid_r, out_valid_nxt;

  tcf_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_color (text_color_w)
  );

  // Pack the request beat for the engine.
  always_comb begin
    req_item.req_type     = tcf_pkg::req_t'(in_req_type);
    req_item.char_code    = in_char_code;
    req_item.pixel_x      = in_pixel_x;
    req_item.pixel_y      = in_pixel_y;
    req_item.color        = in_color;
    req_item.read_address = in_read_address;
  end

  tcf_engine #(
    .DISPLAY_WIDTH  (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
    .GLYPH_COUNT    (GLYPH_COUNT)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_valid),
    .req_ready  (in_ready),
    .req        (req_item),
    .text_color (text_color_w),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // Output register: load a finished result when empty or being drained,
  // drop the valid once the beat is taken.
  assign res_take = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_res_r.read_data;
  assign out_cursor_col_pos = out_res_r.cursor_col_pos;
  assign out_cursor_row_pos = out_res_r.cursor_row_pos;
  assign out_screen_cleared = out_res_r.screen_cleared;

endmodule

>>> rtl/tcf_checker.sv
// Port-level checks of the text console framebuffer, bound to the top level.
// Depends only on the top level's ports.
module tcf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_read_data,
  input logic [9:0]  out_cursor_col_pos,
  input logic [7:0]  out_cursor_row_pos,
  input logic        out_screen_cleared
);

  // A pending result beat holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data) &&
                                $stable(out_cursor_col_pos))
    else $error("result beat changed while stalled");

  // The power-up clearing pass holds off requests.
  a_init_block: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("request taken during reset clear");

  // One request at a time: a taken beat closes the request side.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // A clear never carries read data.
  a_clear_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_screen_cleared |-> out_read_data == 8'd0)
    else $error("cleared result with nonzero read data");

  // Cursor stays inside its start and saturation bounds.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_cursor_col_pos >= 10'd4 && out_cursor_col_pos <= 10'd1020 &&
                  out_cursor_row_pos >= 8'd4)
    else $error("cursor out of range");

endmodule

bind text_console_framebuffer_top tcf_checker u_tcf_checker (.*);

>>> bench/console_mirror_pkg.sv
// Shadow copy of the text console: frame bytes, text cursor and text color,
// plus the queue of results still due from the block. Depends on tcf_pkg.
package console_mirror_pkg;
  import tcf_pkg::*;

  localparam int DISPLAY_WIDTH  = 176;
  localparam int DISPLAY_HEIGHT = 176;
  localparam int GLYPH_COUNT    = 45;
  localparam int STRIDE         = (DISPLAY_WIDTH + 1) / 2;
  localparam int FRAME_BYTES    = STRIDE * DISPLAY_HEIGHT;
  localparam int FONT_GLYPHS    = 45;
  localparam int MAX_REPORTS    = 10;

  // Entry e, slot s sits at index 5*e+s: row (e - g) of glyph g+s, where g is
  // the first glyph of the group of five.
  localparam logic [2:0] FONT_CELLS [225] = '{
    7,2,7,6,5, 5,6,1,1,5, 5,2,2,6,7, 5,2,4,1,1, 7,7,7,6,1,
    7,7,7,7,7, 4,4,1,5,5, 7,7,2,7,7, 1,5,2,5,1, 7,7,2,7,7,
    0,0,1,0,4, 2,2,2,7,2, 0,0,4,0,1, 2,2,2,7,2, 0,4,1,0,4,
    2,0,2,6,3, 5,2,5,5,4, 1,7,7,6,4, 0,2,5,5,4, 2,0,5,6,3,
    6,7,7,3,5, 5,4,4,4,5, 5,6,7,5,7, 5,4,4,5,5, 6,7,4,3,5,
    7,7,5,4,5, 2,1,5,4,7, 2,1,6,4,7, 2,1,5,4,5, 7,6,5,7,5,
    6,3,6,2,6, 5,5,5,5,5, 5,5,6,5,6, 5,5,4,5,5, 5,2,4,3,5,
    3,7,5,5,5, 4,2,5,5,5, 2,2,5,5,7, 1,2,5,2,7, 6,2,7,2,5,
    5,5,7,3,0, 5,5,1,2,0, 2,2,2,2,0, 5,2,4,2,0, 5,2,7,3,2
  };

  class console_mirror;
    logic [7:0] frame [FRAME_BYTES];
    int         cur_x;
    int         cur_y;
    logic [2:0] ink;
    res_t       due_results [$];
    int failures, n_checked, n_print, n_pixel, n_clear, n_wraps, n_read;

    function new();
      fill(3'd0);
      cur_x = CUR_START;
      cur_y = CUR_START;
      ink   = TEXT_COLOR_RESET;
    endfunction

    function void fill(logic [2:0] c);
      foreach (frame[i]) frame[i] = {1'b0, c, 1'b0, c};
    endfunction

    function void plot(int x, int y, logic [2:0] c);
      int a;
      if (x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT) return;
      a = y * STRIDE + x / 2;
      if (x % 2 == 1) frame[a] = (frame[a] & NIB_LO_MASK) | {1'b0, c, 4'h0};
      else frame[a] = (frame[a] & NIB_HI_MASK) | {5'h00, c};
    endfunction

    function void draw_glyph(logic [7:0] code);
      int c, idx, sub, grp;
      logic [2:0] bits;
      if (code[7]) return;
      c = int'(code);
      if (code == CHAR_DOT) c = int'(CHAR_BACKSLASH);
      if (code == CHAR_PLUS) c = int'(CHAR_AT);
      if (c >= int'(CHAR_LOWER_A)) c = c - int'(CASE_SHIFT);
      idx = c - int'(CHAR_ZERO);
      if (idx < 0 || idx >= GLYPH_COUNT || idx >= FONT_GLYPHS) return;
      sub = idx % 5;
      grp = idx - sub;
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        bits = FONT_CELLS[(grp + r) * 5 + sub];
        for (int k = 0; k < 3; k++) begin
          if (bits[2 - k]) plot(cur_x + k, cur_y + r, ink);
        end
      end
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(req_item_t r);
      res_t e;
      e = '0;
      case (r.req_type)
        REQ_PRINT: begin
          n_print++;
          draw_glyph(r.char_code);
          if (r.char_code == CHAR_LF) begin
            if (cur_y + LINE_MARGIN <= DISPLAY_HEIGHT) begin
              cur_y = cur_y + LINE_STEP;
            end else begin
              fill(3'd0);
              e.screen_cleared = 1'b1;
              cur_y = CUR_START;
              n_wraps++;
            end
          end else if (r.char_code == CHAR_CR) begin
            cur_x = CUR_START;
          end else begin
            cur_x = (cur_x + CUR_X_STEP > CUR_X_MAX) ? CUR_X_MAX : cur_x + CUR_X_STEP;
          end
        end
        REQ_PIXEL: begin
          n_pixel++;
          plot(int'(r.pixel_x), int'(r.pixel_y), r.color);
        end
        REQ_CLEAR: begin
          n_clear++;
          fill(r.color);
          e.screen_cleared = 1'b1;
        end
        default: begin
          n_read++;
          if (int'(r.read_address) < FRAME_BYTES) e.read_data = frame[r.read_address];
        end
      endcase
      e.cursor_col_pos = 10'(cur_x);
      e.cursor_row_pos = 8'(cur_y);
      due_results.push_back(e);
    endfunction

    function void check_result(res_t got);
      res_t e;
      n_checked++;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d arrived with nothing due: data %h col %0d row %0d clr %b",
                   n_checked, got.read_data, got.cursor_col_pos, got.cursor_row_pos,
                   got.screen_cleared);
        return;
      end
      e = due_results.pop_front();
      if (got.read_data !== e.read_data || got.cursor_col_pos !== e.cursor_col_pos ||
          got.cursor_row_pos !== e.cursor_row_pos ||
          got.screen_cleared !== e.screen_cleared) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result %0d: expected data %h col %0d row %0d clr %b, got %h %0d %0d %b",
                   n_checked, e.read_data, e.cursor_col_pos, e.cursor_row_pos,
                   e.screen_cleared, got.read_data, got.cursor_col_pos,
                   got.cursor_row_pos, got.screen_cleared);
      end
    endfunction
  endclass

endpackage

>>> bench/tb_text_console_framebuffer_top.sv
// Self-checking bench for text_console_framebuffer_top: directed and random requests,
// random stalls on both channels, text color reprogrammed between phases.
// Depends on tcf_pkg and console_mirror_pkg.
module tb_text_console_framebuffer_top;
  import tcf_pkg::*;
  import console_mirror_pkg::*;

  localparam int TOTAL_ITEMS    = 1700;
  localparam int PHASE_ITEMS    = 420;
  localparam int CALM_TAIL      = 150;
  localparam int CLEAR_BUDGET   = 18;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int HOLD_AT        = 250;
  localparam int HOLD_CYCLES    = 150;
  localparam int DRAIN_CYCLES   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [7:0]  in_char_code = '0;
  logic [7:0]  in_pixel_x = '0;
  logic [7:0]  in_pixel_y = '0;
  logic [2:0]  in_color = '0;
  logic [13:0] in_read_address = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_data;
  logic [9:0]  out_cursor_col_pos;
  logic [7:0]  out_cursor_row_pos;
  logic        out_screen_cleared;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  console_mirror mirror = new();
  int  sent;            // request beats accepted so far
  int  colors_set;      // text color writes
  bit  calm;            // set for the tail of the run: no idling on either side
  bit  long_line_done;
  int  last_pixel_addr;

  always #1 clk = ~clk;

  text_console_framebuffer_top #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT),
    .GLYPH_COUNT   (GLYPH_COUNT)
  ) dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_req_type, .in_char_code, .in_pixel_x, .in_pixel_y,
    .in_color, .in_read_address,
    .out_valid, .out_ready, .out_read_data, .out_cursor_col_pos, .out_cursor_row_pos,
    .out_screen_cleared,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // ---------------------------------------------------------------- item builders
  // Every builder starts from fully random fields, so the fields a request
  // ignores still toggle.
  function automatic req_item_t noise_item();
    req_item_t r;
    r.req_type     = req_t'($urandom_range(0, 3));
    r.char_code    = 8'($urandom_range(0, 255));
    r.pixel_x      = 8'($urandom_range(0, 255));
    r.pixel_y      = 8'($urandom_range(0, 255));
    r.color        = 3'($urandom_range(0, 7));
    r.read_address = 14'($urandom_range(0, 16383));
    return r;
  endfunction

  function automatic req_item_t print_item(logic [7:0] c);
    req_item_t r;
    r = noise_item();
    r.req_type  = REQ_PRINT;
    r.char_code = c;
    return r;
  endfunction

  function automatic req_item_t pixel_item(logic [7:0] x, logic [7:0] y, logic [2:0] c);
    req_item_t r;
    r = noise_item();
    r.req_type = REQ_PIXEL;
    r.pixel_x  = x;
    r.pixel_y  = y;
    r.color    = c;
    return r;
  endfunction

  function automatic req_item_t clear_item(logic [2:0] c);
    req_item_t r;
    r = noise_item();
    r.req_type = REQ_CLEAR;
    r.color    = c;
    return r;
  endfunction

  function automatic req_item_t read_item(int a);
    req_item_t r;
    r = noise_item();
    r.req_type     = REQ_READ;
    r.read_address = 14'(a);
    return r;
  endfunction

  // Mostly codes that land in the font, some that miss it on either side.
  function automatic logic [7:0] glyph_code();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return 8'($urandom_range(48, 92));
    if (pick < 16) return 8'($urandom_range(97, 127));
    if (pick == 16) return CHAR_DOT;
    if (pick == 17) return CHAR_PLUS;
    if (pick == 18) return 8'($urandom_range(32, 47));
    return 8'($urandom_range(128, 255));
  endfunction

  // Frame byte inside or next to the glyph just drawn.
  function automatic int near_text_address();
    int x, y;
    x = mirror.cur_x - int'($urandom_range(0, 7));
    y = mirror.cur_y + int'($urandom_range(0, 5)) - 1;
    if (x < 0) x = 0;
    if (y < 0) y = 0;
    return y * STRIDE + x / 2;
  endfunction

  // ---------------------------------------------------------------- request driver
  // Present one beat and hold it until accepted. Valid stays high on return, so
  // the caller must either issue the next beat or drop valid in the same step.
  task automatic send_beat(req_item_t r);
    in_valid        <= 1'b1;
    in_req_type     <= r.req_type;
    in_char_code    <= r.char_code;
    in_pixel_x      <= r.pixel_x;
    in_pixel_y      <= r.pixel_y;
    in_color        <= r.color;
    in_read_address <= r.read_address;
    do @(posedge clk); while (!in_ready);
    mirror.note_request(r);
    sent++;
  endtask

  task automatic hold_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Idle the sender in short bursts, except in quiet stretches and the tail.
  task automatic issue(req_item_t r);
    if (!calm && (sent % 300) >= 80 && $urandom_range(0, 5) == 0)
      hold_input($urandom_range(1, 3));
    send_beat(r);
  endtask

  // Drop valid and wait until every due result has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (mirror.due_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the text color through the config port, then read it back.
  task automatic program_text_color(logic [2:0] c);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_TEXT_COLOR;
    pwdata  <= {$urandom_range(0, 1) ? 29'h1FFFFFFF : 29'h0, c};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    mirror.ink = c;
    colors_set++;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (got[2:0] !== c) begin
      mirror.failures++;
      if (mirror.failures <= MAX_REPORTS)
        $display("text color read back: expected %0d, got %h", c, got);
    end
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic directed_part();
    issue(print_item(CHAR_ZERO));
    issue(read_item(CUR_START * STRIDE + 2));
    issue(read_item(CUR_START * STRIDE + 3));
    issue(print_item(CHAR_DOT));              // maps onto the last glyph
    issue(print_item(CHAR_PLUS));             // maps onto the '@' glyph
    issue(print_item(8'd122));                // lower case folds to upper
    issue(print_item(8'd127));                // folds past the end of the font
    issue(print_item(8'd47));                 // just below the font
    issue(print_item(8'd128));
    issue(print_item(8'd255));
    issue(read_item((CUR_START + 1) * STRIDE + 4));
    issue(print_item(CHAR_CR));
    issue(print_item(CHAR_LF));
    issue(pixel_item(8'd0, 8'd0, 3'd7));
    issue(pixel_item(8'd1, 8'd0, 3'd5));      // odd x goes to the high nibble
    issue(read_item(0));
    issue(pixel_item(8'd175, 8'd175, 3'd3));
    issue(pixel_item(8'd176, 8'd0, 3'd1));    // clipped on x
    issue(pixel_item(8'd0, 8'd176, 3'd6));    // clipped on y
    issue(pixel_item(8'd255, 8'd255, 3'd7));
    issue(read_item(FRAME_BYTES - 1));
    issue(read_item(FRAME_BYTES));            // first address past the store
    issue(read_item(16383));
    issue(clear_item(3'd5));
    issue(read_item($urandom_range(0, FRAME_BYTES - 1)));
  endtask

  // One line of text with reads of what was drawn, then a line ending. Once in
  // the run the line is long enough to pin the cursor at its limit.
  task automatic text_line();
    int len;
    len = $urandom_range(1, 24);
    if (!long_line_done && (sent > 900 || $urandom_range(0, 39) == 0)) begin
      len = 262;
      long_line_done = 1'b1;
    end
    for (int i = 0; i < len; i++) begin
      issue(print_item(glyph_code()));
      if ($urandom_range(0, 4) == 0) issue(read_item(near_text_address()));
    end
    case ($urandom_range(0, 3))
      0: issue(print_item(CHAR_LF));
      1: issue(print_item(CHAR_CR));
      2: begin
        issue(print_item(CHAR_LF));
        issue(print_item(CHAR_CR));
      end
      default: begin
        issue(print_item(CHAR_CR));
        issue(print_item(CHAR_LF));
      end
    endcase
  endtask

  task automatic pixel_burst();
    int n, x, y;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        x = $urandom_range(0, 255);
        y = $urandom_range(0, 255);
      end else begin
        x = $urandom_range(0, DISPLAY_WIDTH - 1);
        y = $urandom_range(0, DISPLAY_HEIGHT - 1);
      end
      issue(pixel_item(8'(x), 8'(y), 3'($urandom_range(0, 7))));
      if (x < DISPLAY_WIDTH && y < DISPLAY_HEIGHT) last_pixel_addr = y * STRIDE + x / 2;
    end
    repeat ($urandom_range(1, 2)) issue(read_item(last_pixel_addr));
  endtask

  task automatic random_phase(int target);
    int pick;
    req_item_t r;
    while (sent < target) begin
      if (sent >= TOTAL_ITEMS - CALM_TAIL) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        text_line();
      end else if (pick < 70) begin
        pixel_burst();
      end else if (pick < 80) begin
        if ($urandom_range(0, 1) == 0) issue(read_item($urandom_range(0, FRAME_BYTES - 1)));
        else issue(read_item($urandom_range(FRAME_BYTES, 16383)));
      end else if (pick < 84 && mirror.n_clear < CLEAR_BUDGET) begin
        issue(clear_item(3'($urandom_range(0, 7))));
        issue(read_item($urandom_range(0, FRAME_BYTES - 1)));
      end else begin
        // Noise: any request with any fields; keep the slow clears rationed.
        r = noise_item();
        if (r.req_type == REQ_CLEAR && mirror.n_clear >= CLEAR_BUDGET) r.req_type = REQ_READ;
        issue(r);
      end
    end
  endtask

  // ---------------------------------------------------------------- main sequence
  initial begin
    logic [2:0] palette [4];
    palette[0] = 3'd0;
    palette[1] = 3'd7;
    palette[2] = 3'($urandom_range(1, 6));
    palette[3] = 3'($urandom_range(0, 7));
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests run under the reset text color.
    directed_part();
    for (int p = 0; p < 4; p++) begin
      settle();
      program_text_color(palette[p]);
      random_phase(p == 3 ? TOTAL_ITEMS : 25 + PHASE_ITEMS * (p + 1));
    end

    // Drain, then give any stray beat time to show up.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.due_results.size() != 0) mirror.failures++;

    $display("ran %0d requests: %0d prints, %0d pixel writes, %0d clears, %0d reads",
             sent, mirror.n_print, mirror.n_pixel, mirror.n_clear, mirror.n_read);
    $display("checked %0d results, %0d screen wraps, %0d text colors, %0d failures",
             mirror.n_checked, mirror.n_wraps, colors_set, mirror.failures);
    if (mirror.failures == 0) begin
      $display("tb_text_console_framebuffer_top: clean");
    end else begin
      $display("tb_text_console_framebuffer_top: errors");
    end
    $finish;
  end

  // ---------------------------------------------------------------- result side
  // Receiver: short random stalls, quiet stretches, and one long hold-off so the
  // block fills and pushes back on the request channel.
  initial begin
    bit held;
    held = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!held && mirror.n_checked >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && (mirror.n_checked % 200) >= 60 && $urandom_range(0, 6) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every result beat against the oldest due result.
  initial begin
    res_t got;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got.read_data      = out_read_data;
        got.cursor_col_pos = out_cursor_col_pos;
        got.cursor_row_pos = out_cursor_row_pos;
        got.screen_cleared = out_screen_cleared;
        mirror.check_result(got);
      end
    end
  end

  // Watchdog: end the run if no beat moves on either channel for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("tb_text_console_framebuffer_top: errors");
    $finish;
  end

endmodule

>>> files.f
rtl/tcf_pkg.sv
rtl/tcf_cfg_regs.sv
rtl/tcf_engine.sv
rtl/text_console_framebuffer_top.sv
rtl/tcf_checker.sv
bench/console_mirror_pkg.sv
bench/tb_text_console_framebuffer_top.sv
